// ===== rtl/wgas_pkg.sv =====
`default_nettype none
package wgas_pkg;

    // Slot table size and derived widths
    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int WMEM_DEPTH   = MAX_VERTICES * MAX_VERTICES;
    localparam int WMEM_ADDR_W  = $clog2(WMEM_DEPTH);

    localparam int KEY_W    = 32;
    localparam int WEIGHT_W = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Stream payload widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD_VERTEX    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_EDGE      = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_VERTEX = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_EDGE   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY_VERTEX  = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY_EDGE    = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic take_rdata;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_read;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/wgas_ram.sv =====
`default_nettype none
module wgas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire logic [WIDTH-1:0]           wdata,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wgas_ctrl.sv =====
`default_nettype none
module wgas_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire wgas_pkg::stat_t stat,
    output wgas_pkg::cmd_t     cmd
);

    import wgas_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    // Output register is free when empty or being emptied this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_PUT) && out_free);
    assign accept   = in_valid && in_ready;

    assign cmd.load_item  = accept;
    assign cmd.exec       = (state_reg == S_EXEC);
    assign cmd.take_rdata = (state_reg == S_READ);
    assign cmd.load_out   = (state_reg == S_PUT) && out_free;

    assign out_valid = out_valid_reg;

    // Sequence one operation: execute, optional weight read, hand over
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.need_read ? S_READ : S_PUT;
            end
            S_READ:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track the output beat
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wgas_dp.sv =====
`default_nettype none
module wgas_dp (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire wgas_pkg::cmd_t                          cmd,
    output wgas_pkg::stat_t                              stat,
    input  wire logic [wgas_pkg::OP_W-1:0]               in_op,
    input  wire logic signed [wgas_pkg::KEY_W-1:0]       in_key_a,
    input  wire logic signed [wgas_pkg::KEY_W-1:0]       in_key_b,
    input  wire logic signed [wgas_pkg::WEIGHT_W-1:0]    in_edge_weight,
    output logic [wgas_pkg::STATUS_W-1:0]                out_status,
    output logic                                         out_found,
    output logic signed [wgas_pkg::WEIGHT_W-1:0]         out_weight
);

    import wgas_pkg::*;

    // Held operation
    logic [OP_W-1:0]            op_reg;
    logic signed [KEY_W-1:0]    key_a_reg;
    logic signed [KEY_W-1:0]    key_b_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;

    // Graph state
    logic signed [KEY_W-1:0]    slot_key_reg  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]    slot_valid_reg;
    logic [MAX_VERTICES-1:0]    edge_rows_reg [MAX_VERTICES];

    // Result staging and output beat
    logic [STATUS_W-1:0]        res_status_reg;
    logic                       res_found_reg;
    logic signed [WEIGHT_W-1:0] res_weight_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic                       out_found_reg;
    logic signed [WEIGHT_W-1:0] out_weight_reg;

    // Match and decode
    logic [MAX_VERTICES-1:0]    hit_a;
    logic [MAX_VERTICES-1:0]    hit_b;
    logic [VIDX_W-1:0]          sa_idx;
    logic [VIDX_W-1:0]          sb_idx;
    logic [VIDX_W-1:0]          free_idx;
    logic                       a_hit;
    logic                       b_hit;
    logic                       free_any;
    logic                       edge_set;
    logic                       do_add_v;
    logic                       do_add_e;
    logic                       do_rm_v;
    logic                       do_rm_e;
    logic                       need_read;
    logic [STATUS_W-1:0]        status_c;
    logic                       found_c;

    // Weight memory port
    logic                       ram_en;
    logic [WMEM_ADDR_W-1:0]     ram_addr;
    logic [WEIGHT_W-1:0]        ram_rdata;

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= in_op;
            key_a_reg  <= in_key_a;
            key_b_reg  <= in_key_b;
            weight_reg <= in_edge_weight;
        end
    end

    // Match both keys against every valid slot at once
    always_comb
    begin
        for (int s = 0; s < MAX_VERTICES; s++)
        begin
            hit_a[s] = slot_valid_reg[s] && (slot_key_reg[s] == key_a_reg);
            hit_b[s] = slot_valid_reg[s] && (slot_key_reg[s] == key_b_reg);
        end
    end

    // Encode the one-hot matches; keys are unique among valid slots
    always_comb
    begin
        sa_idx = '0;
        sb_idx = '0;
        for (int s = 0; s < MAX_VERTICES; s++)
        begin
            if (hit_a[s])
            begin
                sa_idx = sa_idx | VIDX_W'(s);
            end
            if (hit_b[s])
            begin
                sb_idx = sb_idx | VIDX_W'(s);
            end
        end
    end

    assign a_hit = |hit_a;
    assign b_hit = |hit_b;

    // Pick the lowest free slot
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int s = MAX_VERTICES - 1; s >= 0; s--)
        begin
            if (!slot_valid_reg[s])
            begin
                free_idx = VIDX_W'(s);
                free_any = 1'b1;
            end
        end
    end

    assign edge_set = edge_rows_reg[sa_idx][sb_idx];

    // Decide the operation outcome
    always_comb
    begin
        status_c  = ST_NO_CHANGE;
        found_c   = 1'b0;
        do_add_v  = 1'b0;
        do_add_e  = 1'b0;
        do_rm_v   = 1'b0;
        do_rm_e   = 1'b0;
        need_read = 1'b0;
        unique case (op_reg)
            OP_ADD_VERTEX:
            begin
                if (!a_hit)
                begin
                    if (free_any)
                    begin
                        do_add_v = 1'b1;
                        status_c = ST_DONE;
                    end
                    else
                    begin
                        status_c = ST_FULL;
                    end
                end
            end
            OP_ADD_EDGE:
            begin
                if (a_hit && b_hit && !edge_set)
                begin
                    do_add_e = 1'b1;
                    status_c = ST_DONE;
                end
            end
            OP_REMOVE_VERTEX:
            begin
                if (a_hit)
                begin
                    do_rm_v  = 1'b1;
                    status_c = ST_DONE;
                end
            end
            OP_REMOVE_EDGE:
            begin
                if (a_hit && b_hit && edge_set)
                begin
                    do_rm_e  = 1'b1;
                    status_c = ST_DONE;
                end
            end
            OP_QUERY_VERTEX:
            begin
                found_c  = a_hit;
                status_c = a_hit ? ST_DONE : ST_NO_CHANGE;
            end
            OP_QUERY_EDGE:
            begin
                if (a_hit && b_hit && edge_set)
                begin
                    found_c   = 1'b1;
                    need_read = 1'b1;
                    status_c  = ST_DONE;
                end
            end
            default:
            begin
                status_c = ST_NO_CHANGE;
            end
        endcase
    end

    assign stat.need_read = need_read;

    // Weight memory: write on add edge, read on a found edge query
    assign ram_en   = cmd.exec && (do_add_e || need_read);
    assign ram_addr = WMEM_ADDR_W'(WMEM_ADDR_W'(sa_idx) * WMEM_ADDR_W'(MAX_VERTICES)
                                   + WMEM_ADDR_W'(sb_idx));

    wgas_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WMEM_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (do_add_e),
        .addr  (ram_addr),
        .wdata (weight_reg),
        .rdata (ram_rdata)
    );

    // Slot keys: written when a vertex takes a slot
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MAX_VERTICES; s++)
        begin
            if (cmd.exec && do_add_v && (free_idx == VIDX_W'(s)))
            begin
                slot_key_reg[s] <= key_a_reg;
            end
        end
    end

    // Slot valid bits and edge presence matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                edge_rows_reg[r] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                if (do_add_v && (free_idx == VIDX_W'(r)))
                begin
                    slot_valid_reg[r] <= 1'b1;
                    edge_rows_reg[r]  <= '0;
                end
                if (do_rm_v)
                begin
                    // Clear the row of the removed vertex and its column everywhere
                    if (sa_idx == VIDX_W'(r))
                    begin
                        slot_valid_reg[r] <= 1'b0;
                        edge_rows_reg[r]  <= '0;
                    end
                    else
                    begin
                        edge_rows_reg[r][sa_idx] <= 1'b0;
                    end
                end
                if (do_add_e && (sa_idx == VIDX_W'(r)))
                begin
                    edge_rows_reg[r][sb_idx] <= 1'b1;
                end
                if (do_rm_e && (sa_idx == VIDX_W'(r)))
                begin
                    edge_rows_reg[r][sb_idx] <= 1'b0;
                end
            end
        end
    end

    // Stage the result; the weight follows from memory when needed
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= status_c;
            res_found_reg  <= found_c;
            res_weight_reg <= '0;
        end
        else if (cmd.take_rdata)
        begin
            res_weight_reg <= ram_rdata;
        end
    end

    // Output beat register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_weight_reg <= res_weight_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_weight = out_weight_reg;

endmodule
`default_nettype wire

// ===== rtl/weighted_graph_adjacency_store.sv =====
`default_nettype none
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   op, key_a, key_b, edge_weight
// m_axis    out  m_axis_tvalid/m_axis_tready   status, found, weight_out
//
// One operation at a time. An ordinary operation goes through key match and table
// update, then hand-over to the output register, before the next accept; a query
// that finds an edge adds a step between the two, the registered read of the
// single-port weight memory.
// Reset clears the slot valid bits and the edge matrix at once; no clearing pass.
// A stalled output beat holds in its register; the next operation may run
// meanwhile and then waits to hand over its result.
module weighted_graph_adjacency_store (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [2:0] op, [34:3] key_a, [66:35] key_b, [98:67] edge_weight, rest zero
    input  wire logic [wgas_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] status, [2] found, [34:3] weight_out, rest zero
    output logic [wgas_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    import wgas_pkg::*;

    cmd_t                       cmd;
    stat_t                      stat;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic signed [WEIGHT_W-1:0] weight_out;

    wgas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wgas_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_op          (s_axis_tdata[2:0]),
        .in_key_a       (s_axis_tdata[34:3]),
        .in_key_b       (s_axis_tdata[66:35]),
        .in_edge_weight (s_axis_tdata[98:67]),
        .out_status     (status),
        .out_found      (found),
        .out_weight     (weight_out)
    );

    // Pack the result beat
    assign m_axis_tdata = {5'd0, weight_out, found, status};

    // An accepted beat executes in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.exec)
        else $error("accepted beat did not execute");

    // A found edge query collects the memory data next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.need_read) |=> cmd.take_rdata)
        else $error("weight read not collected");

    // Loading the output register presents a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // No new operation is taken while one is executing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.take_rdata) |-> !s_axis_tready)
        else $error("input ready during execution");

endmodule
`default_nettype wire
